/* design/rpc_pkg.sv */
// Package for the relation property checker: sizes, payload types and unit interfaces.
`default_nettype none

package rpc_pkg;

  localparam int unsigned MAX_PAIRS = 128;
  localparam int unsigned ELEM_BITS = 8;
  localparam int unsigned FIELD_W   = 8;
  localparam int unsigned PAIRS_W   = 8;
  localparam int unsigned IDX_W     = $clog2(MAX_PAIRS);
  localparam int unsigned CNT_W     = $clog2(MAX_PAIRS + 1);

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    logic [FIELD_W-1:0] first_elem;
    logic [FIELD_W-1:0] second_elem;
    logic               last_pair;
  } in_item_t;

  typedef struct packed {
    logic               reflexive_flag;
    logic               irreflexive_flag;
    logic               symmetric_flag;
    logic               antisymmetric_flag;
    logic               asymmetric_flag;
    logic               transitive_flag;
    logic [PAIRS_W-1:0] pairs_held;
    logic               overflow_flag;
  } out_item_t;

  // One stored pair of the relation.
  typedef struct packed {
    elem_t a;
    elem_t b;
  } pair_t;

  // Search keys of the shared compare unit.
  typedef struct packed {
    elem_t x;
    elem_t y;
    elem_t z;
  } key_t;

  // Match results: (x,x), (y,y), (y,x) and (x,z).
  typedef struct packed {
    logic xx;
    logic yy;
    logic yx;
    logic xz;
  } hit_t;

endpackage

`default_nettype wire

/* design/rpc_match.sv */
// Shared compare unit: matches one stored pair against the current search keys.
`default_nettype none

module rpc_match import rpc_pkg::*; (
  input  pair_t entry_i,
  input  key_t  key_i,
  output hit_t  hit_o
);

  logic a_is_x, a_is_y, b_is_x, b_is_y, b_is_z;

  assign a_is_x = (entry_i.a == key_i.x);
  assign a_is_y = (entry_i.a == key_i.y);
  assign b_is_x = (entry_i.b == key_i.x);
  assign b_is_y = (entry_i.b == key_i.y);
  assign b_is_z = (entry_i.b == key_i.z);

  assign hit_o.xx = a_is_x & b_is_x;
  assign hit_o.yy = a_is_y & b_is_y;
  assign hit_o.yx = a_is_y & b_is_x;
  assign hit_o.xz = a_is_x & b_is_z;

endmodule

`default_nettype wire

/* design/rpc_seq.sv */
// Pair table and sequencer that walks it to evaluate the relation properties.
`default_nettype none

module rpc_seq import rpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output logic      busy_o,
  output logic      res_valid_o,
  input  logic      res_take_i,
  output out_item_t res_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_FETCH_I = 12'b0000_0000_0010,
    S_LOAD_I  = 12'b0000_0000_0100,
    S_SCAN_H  = 12'b0000_0000_1000,
    S_UPD_H   = 12'b0000_0001_0000,
    S_FETCH_J = 12'b0000_0010_0000,
    S_LOAD_J  = 12'b0000_0100_0000,
    S_SCAN_T  = 12'b0000_1000_0000,
    S_CHK_T   = 12'b0001_0000_0000,
    S_NEXT_J  = 12'b0010_0000_0000,
    S_NEXT_I  = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  cnt_t   cnt_q;
  logic   drop_q;
  idx_t   i_q, j_q;
  cnt_t   k_q;
  elem_t  x_q, y_q, z_q;
  hit_t   hits_q;
  hit_t   hit;
  key_t   key;
  logic   refl_q, irrefl_q, sym_q, antisym_q, asym_q, trans_q;

  pair_t  mem [MAX_PAIRS];
  pair_t  rd_a_q, rd_b_q;
  pair_t  wr_pair;
  logic   wr_en;
  idx_t   addr_a;
  logic   table_full;
  logic   i_last, j_last, k_end;

  assign table_full = (cnt_q >= CNT_W'(MAX_PAIRS));
  assign wr_en      = accept_i & ~table_full;
  assign wr_pair.a  = elem_t'(item_i.first_elem);
  assign wr_pair.b  = elem_t'(item_i.second_elem);
  assign addr_a     = (state_q == S_FETCH_J) ? j_q : i_q;

  assign i_last = ((CNT_W'(i_q) + CNT_W'(1)) == cnt_q);
  assign j_last = ((CNT_W'(j_q) + CNT_W'(1)) == cnt_q);
  assign k_end  = (k_q == cnt_q);

  // Port A reads the outer or middle entry, port B walks the scan index.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= wr_pair;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[k_q[IDX_W-1:0]];
  end

  assign key.x = x_q;
  assign key.y = y_q;
  assign key.z = z_q;

  rpc_match u_match (
    .entry_i (rd_b_q),
    .key_i   (key),
    .hit_o   (hit)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept_i && item_i.last_pair) begin
          state_d = S_FETCH_I;
        end
      end
      S_FETCH_I: state_d = S_LOAD_I;
      S_LOAD_I:  state_d = S_SCAN_H;
      S_SCAN_H: begin
        if (k_end) begin
          state_d = S_UPD_H;
        end
      end
      S_UPD_H:   state_d = trans_q ? S_FETCH_J : S_NEXT_I;
      S_FETCH_J: state_d = S_LOAD_J;
      S_LOAD_J:  state_d = (rd_a_q.a == y_q) ? S_SCAN_T : S_NEXT_J;
      S_SCAN_T: begin
        if (k_end) begin
          state_d = S_CHK_T;
        end
      end
      S_CHK_T:   state_d = hits_q.xz ? S_NEXT_J : S_NEXT_I;
      S_NEXT_J:  state_d = j_last ? S_NEXT_I : S_FETCH_J;
      S_NEXT_I:  state_d = i_last ? S_DONE : S_FETCH_I;
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_i) begin
        if (!table_full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end else if (state_q == S_DONE && res_take_i) begin
        cnt_q  <= '0;
        drop_q <= 1'b0;
      end
    end
  end

  // Scan data is read through a register behind the scan index, so index zero compares nothing.
  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      S_IDLE: begin
        if (accept_i) begin
          refl_q    <= 1'b1;
          irrefl_q  <= 1'b1;
          sym_q     <= 1'b1;
          antisym_q <= 1'b1;
          asym_q    <= 1'b1;
          trans_q   <= 1'b1;
          i_q       <= '0;
        end
      end
      S_LOAD_I: begin
        x_q    <= rd_a_q.a;
        y_q    <= rd_a_q.b;
        k_q    <= '0;
        hits_q <= '0;
        if (rd_a_q.a == rd_a_q.b) begin
          irrefl_q <= 1'b0;
        end
      end
      S_SCAN_H, S_SCAN_T: begin
        k_q <= k_q + CNT_W'(1);
        if (k_q != '0) begin
          hits_q <= hits_q | hit;
        end
      end
      S_UPD_H: begin
        j_q <= '0;
        if (!(hits_q.xx && hits_q.yy)) begin
          refl_q <= 1'b0;
        end
        if (hits_q.yx) begin
          asym_q <= 1'b0;
          if (x_q != y_q) begin
            antisym_q <= 1'b0;
          end
        end else begin
          sym_q <= 1'b0;
        end
      end
      S_LOAD_J: begin
        z_q    <= rd_a_q.b;
        k_q    <= '0;
        hits_q <= '0;
      end
      S_CHK_T: begin
        if (!hits_q.xz) begin
          trans_q <= 1'b0;
        end
      end
      S_NEXT_J: j_q <= j_q + idx_t'(1);
      S_NEXT_I: i_q <= i_q + idx_t'(1);
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_o.reflexive_flag     = refl_q;
  assign res_o.irreflexive_flag   = irrefl_q;
  assign res_o.symmetric_flag     = sym_q;
  assign res_o.antisymmetric_flag = antisym_q;
  assign res_o.asymmetric_flag    = asym_q;
  assign res_o.transitive_flag    = trans_q;
  assign res_o.pairs_held         = PAIRS_W'(cnt_q);
  assign res_o.overflow_flag      = drop_q;

endmodule

`default_nettype wire

/* design/relation_property_checker.sv */
// Top level of the relation property checker: handshakes and result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_item_t)
//
// A pair without the last mark is written into the pair table unless it is full, and the next can follow at once.
// After the last pair the sequencer walks the pair table through one compare unit over
// two read ports: for each outer pair it scans the table once, and while transitivity
// holds it fetches each middle pair and scans the table again when that pair chains on.
// in_stall_o stays high until the result is in the output register. Reset clears the
// pair count and the overflow mark; the table is not cleared.
// A result held under out_stall_i does not block loading of the next relation.
`default_nettype none

module relation_property_checker import rpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      busy;
  logic      accept;
  logic      res_valid;
  logic      res_take;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;
  assign res_take   = res_valid & (~out_valid_q | ~out_stall_i);

  rpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* design/rpc_checker.sv */
// Port-level checker for the relation property checker and its bind statement.
`default_nettype none

module rpc_checker import rpc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Accepting the last pair starts an evaluation, so input is stalled next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_pair |=> in_stall_o)
    else $error("no evaluation after last pair");

  // A relation always holds a pair, so it cannot be both reflexive and irreflexive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.reflexive_flag && out_data_o.irreflexive_flag))
    else $error("reflexive and irreflexive both set");

  // Asymmetry implies antisymmetry and irreflexivity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.asymmetric_flag |->
      out_data_o.antisymmetric_flag && out_data_o.irreflexive_flag)
    else $error("asymmetric without antisymmetric or irreflexive");

  // An evaluated relation holds at least one pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pairs_held != '0)
    else $error("result with no pairs held");

endmodule

bind relation_property_checker rpc_checker u_rpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
